@@ design/assert_macros.svh @@
// assertion macros used by the ppm frame decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PPMFD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPMFD_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PPMFD_ASSERT(label, clk, rst_n, prop, msg)
`define PPMFD_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ design/ppmfd_pkg.sv @@
// types and constants of the ppm frame decoder
`timescale 1ns / 1ps
package ppmfd_pkg;

	localparam int MAX_RESULTS = 8;

	localparam logic [2:0] ST_WAITING = 3'd0;
	localparam logic [2:0] ST_SYNC    = 3'd1;
	localparam logic [2:0] ST_STORED  = 3'd2;
	localparam logic [2:0] ST_LOST    = 3'd3;
	localparam logic [2:0] ST_REPORT  = 3'd4;

	localparam logic [1:0] CFG_SYNC_MIN  = 2'd0;
	localparam logic [1:0] CFG_PULSE_MIN = 2'd1;
	localparam logic [1:0] CFG_PULSE_MAX = 2'd2;

	localparam logic [15:0] SYNC_MIN_RST  = 16'd2200;
	localparam logic [15:0] PULSE_MIN_RST = 16'd950;
	localparam logic [15:0] PULSE_MAX_RST = 16'd2050;

	typedef struct packed {
		logic [31:0] timestamp_us;
		logic        is_ppm_edge;
	} edge_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  channel_index;
		logic [15:0] pulse_width_us;
		logic        frame_seen;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [15:0] sync_min_us;
		logic [15:0] pulse_min_us;
		logic [15:0] pulse_max_us;
	} cfg_t;

	typedef struct packed {
		logic [15:0] gap;
		logic        sync_hit;
		logic        pulse_hit;
	} gap_info_t;

endpackage

@@ design/ppm_frame_decoder_unit.sv @@
// Decodes a ppm pulse stream from edge timestamps. An edge that does not complete a frame
// is accepted and yields its single result through the output register, and
// the next edge may be accepted in the cycle after. The edge that stores the last channel
// writes it into the channel ram and the block then reads the frame back through the
// ram's one read port, one report per cycle while result_ready is high: such an edge
// holds edge_ready low until the last of its min(CHANNELS, 8) reports is loaded. Edges with
// is_ppm_edge low are taken and change nothing. No clearing pass follows reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppm_frame_decoder_unit #(
	parameter int CHANNELS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 edge_valid,
	output logic                 edge_ready,
	input  ppmfd_pkg::edge_t     edge_data,
	output logic                 result_valid,
	input  logic                 result_ready,
	output ppmfd_pkg::result_t   result_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	// channel count limited to 1..16
	localparam int NCH = (CHANNELS < 1) ? 1 : ((CHANNELS > 16) ? 16 : CHANNELS);
	localparam int NREP = (NCH < ppmfd_pkg::MAX_RESULTS) ? NCH
		: ppmfd_pkg::MAX_RESULTS;
	localparam int AW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int RW = $clog2(NREP + 1);
	localparam logic [AW-1:0] LAST_CH  = AW'(NCH - 1);
	localparam logic [AW-1:0] LAST_REP = AW'(NREP - 1);
	localparam logic [RW-1:0] NREP_C   = RW'(NREP);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_REPORT = 1'b1;

	logic                 state_q;
	ppmfd_pkg::cfg_t      cfg_q;
	logic [15:0]          prev_q;
	logic                 locked_q;
	logic [AW-1:0]        count_q;
	logic                 upd_q;
	logic [RW-1:0]        rd_k_q;
	logic [AW-1:0]        rep_k_q;
	logic                 pend_q;
	logic                 valid_q;
	ppmfd_pkg::result_t   res_q;

	ppmfd_pkg::gap_info_t info;
	logic                 take;
	logic                 accept;
	logic                 locked_n;
	logic [AW-1:0]        count_n;
	logic                 upd_n;
	logic                 wr_en;
	logic                 frame_done;
	logic                 single_load;
	logic [2:0]           st_n;
	logic [3:0]           idx_n;
	logic                 issue;
	logic                 load;
	logic [15:0]          ram_rdata;
	logic                 in_report;
	logic                 out_rep_last;
	logic                 rep_idx_last;
	logic                 out_lost;
	logic                 done_take;
	logic                 cnt_zero;

	assign edge_ready = (state_q == S_IDLE) && (!valid_q || result_ready);
	assign take       = edge_valid && edge_ready;
	assign accept     = take && edge_data.is_ppm_edge;
	assign cfg_ready  = 1'b1;

	ppmfd_gap u_gap (
		.now_us  (edge_data.timestamp_us[15:0]),
		.prev_us (prev_q),
		.cfg     (cfg_q),
		.info    (info)
	);

	always_comb begin
		locked_n   = locked_q;
		count_n    = count_q;
		upd_n      = upd_q;
		wr_en      = 1'b0;
		frame_done = 1'b0;
		st_n       = ppmfd_pkg::ST_WAITING;
		idx_n      = 4'd0;
		if (!locked_q) begin
			if (info.sync_hit) begin
				locked_n = 1'b1;
				count_n  = '0;
				upd_n    = 1'b0;
				st_n     = ppmfd_pkg::ST_SYNC;
			end
		end else if (info.sync_hit) begin
			count_n = '0;
			upd_n   = 1'b1;
			st_n    = ppmfd_pkg::ST_SYNC;
		end else if (info.pulse_hit) begin
			wr_en = 1'b1;
			st_n  = ppmfd_pkg::ST_STORED;
			idx_n = 4'(count_q);
			if (count_q == LAST_CH) begin
				count_n    = '0;
				frame_done = 1'b1;
			end else begin
				count_n = count_q + AW'(1);
			end
		end else begin
			locked_n = 1'b0;
			st_n     = ppmfd_pkg::ST_LOST;
		end
	end

	assign single_load = accept && !frame_done;
	assign load  = (state_q == S_REPORT) && pend_q && (!valid_q || result_ready);
	assign issue = (state_q == S_REPORT) && (rd_k_q != NREP_C) && (!pend_q || load);

	ppmfd_ram #(
		.WIDTH (16),
		.DEPTH (NCH)
	) u_store (
		.clk   (clk),
		.we    (accept && wr_en),
		.waddr (count_q),
		.wdata (info.gap),
		.re    (issue),
		.raddr (rd_k_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_min_us  <= ppmfd_pkg::SYNC_MIN_RST;
			cfg_q.pulse_min_us <= ppmfd_pkg::PULSE_MIN_RST;
			cfg_q.pulse_max_us <= ppmfd_pkg::PULSE_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ppmfd_pkg::CFG_SYNC_MIN: begin
					cfg_q.sync_min_us <= cfg_data;
				end
				ppmfd_pkg::CFG_PULSE_MIN: begin
					cfg_q.pulse_min_us <= cfg_data;
				end
				ppmfd_pkg::CFG_PULSE_MAX: begin
					cfg_q.pulse_max_us <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			prev_q   <= '0;
			locked_q <= 1'b0;
			count_q  <= '0;
			upd_q    <= 1'b0;
			rd_k_q   <= '0;
			rep_k_q  <= '0;
			pend_q   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				prev_q   <= edge_data.timestamp_us[15:0];
				locked_q <= locked_n;
				count_q  <= count_n;
				upd_q    <= upd_n;
				if (frame_done) begin
					state_q <= S_REPORT;
					rd_k_q  <= '0;
					rep_k_q <= '0;
					pend_q  <= 1'b0;
				end
			end
			if (state_q == S_REPORT) begin
				if (issue) begin
					rd_k_q <= rd_k_q + RW'(1);
					pend_q <= 1'b1;
				end else if (load) begin
					pend_q <= 1'b0;
				end
				if (load) begin
					rep_k_q <= rep_k_q + AW'(1);
					if (rep_k_q == LAST_REP) begin
						state_q <= S_IDLE;
					end
				end
			end
			if (single_load || load) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (single_load) begin
			res_q.status         <= st_n;
			res_q.channel_index  <= idx_n;
			res_q.pulse_width_us <= info.gap;
			res_q.frame_seen     <= upd_n;
			res_q.last           <= 1'b1;
		end else if (load) begin
			res_q.status         <= ppmfd_pkg::ST_REPORT;
			res_q.channel_index  <= 4'(rep_k_q);
			res_q.pulse_width_us <= ram_rdata;
			res_q.frame_seen     <= upd_q;
			res_q.last           <= (rep_k_q == LAST_REP);
		end
	end

	assign result_valid = valid_q;
	assign result_data  = res_q;

	assign in_report    = (state_q == S_REPORT);
	assign out_rep_last = valid_q && (res_q.status == ppmfd_pkg::ST_REPORT) && res_q.last;
	assign rep_idx_last = (res_q.channel_index == 4'(LAST_REP));
	assign out_lost     = valid_q && (res_q.status == ppmfd_pkg::ST_LOST);
	assign done_take    = accept && frame_done;
	assign cnt_zero     = (count_q == '0);

	`PPMFD_NEVER(a_no_take_in_report, clk, arst_n, in_report && edge_ready, "edge in report")
	`PPMFD_ASSERT(a_pend_in_report, clk, arst_n, pend_q |-> in_report, "read pending outside")
	`PPMFD_ASSERT(a_rep_last_idx, clk, arst_n, out_rep_last |-> rep_idx_last, "bad final index")
	`PPMFD_ASSERT(a_lost_unlocks, clk, arst_n, out_lost |-> !locked_q, "lost while locked")
	`PPMFD_ASSERT(a_done_locked, clk, arst_n, done_take |=> (locked_q && cnt_zero), "bad frame end")

endmodule

@@ design/ppmfd_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ppmfd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/ppmfd_gap.sv @@
// gap measurement and window classification of one ppm edge
`timescale 1ns / 1ps
module ppmfd_gap (
	input  logic [15:0]          now_us,
	input  logic [15:0]          prev_us,
	input  ppmfd_pkg::cfg_t      cfg,
	output ppmfd_pkg::gap_info_t info
);

	logic [15:0] gap;

	assign gap = now_us - prev_us;

	always_comb begin
		info.gap       = gap;
		info.sync_hit  = (gap >= cfg.sync_min_us);
		info.pulse_hit = (gap >= cfg.pulse_min_us) && (gap <= cfg.pulse_max_us);
	end

endmodule

@@ tb/tb_ppm_frame_decoder_unit.sv @@
// self-checking testbench for the ppm frame decoder unit
`timescale 1ns / 1ps
module tb_ppm_frame_decoder_unit;

	localparam int NUM_CH = 8;
	localparam int NUM_REPORTS = NUM_CH < ppmfd_pkg::MAX_RESULTS ? NUM_CH
		: ppmfd_pkg::MAX_RESULTS;
	localparam int NUM_CHUNKS = 8;
	localparam int CHUNK_EDGES = 55;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic edge_valid = 1'b0;
	logic edge_ready;
	ppmfd_pkg::edge_t edge_data = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	ppmfd_pkg::result_t result_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = ppmfd_pkg::CFG_SYNC_MIN;
	logic [15:0] cfg_data = '0;

	// decoder state as the block should hold it
	logic [15:0] cfg_sync_min = ppmfd_pkg::SYNC_MIN_RST;
	logic [15:0] cfg_pulse_min = ppmfd_pkg::PULSE_MIN_RST;
	logic [15:0] cfg_pulse_max = ppmfd_pkg::PULSE_MAX_RST;
	logic [15:0] prev_edge_us = '0;
	logic is_locked = 1'b0;
	logic [3:0] chan_count = '0;
	logic update_seen = 1'b0;
	logic [15:0] chan_widths [NUM_CH];

	ppmfd_pkg::edge_t edges_to_send [$];
	ppmfd_pkg::result_t decoded_results [$];
	logic [31:0] clock_us = '0;
	logic idle_on = 1'b1;
	logic hold_off = 1'b0;
	int send_wait = 0;
	int recv_wait = 0;
	int error_count = 0;

	ppm_frame_decoder_unit #(
		.CHANNELS(NUM_CH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.edge_valid(edge_valid),
		.edge_ready(edge_ready),
		.edge_data(edge_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data(result_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		foreach (chan_widths[i])
			chan_widths[i] = '0;
	end

	function automatic int draw_wait();
		return idle_on ? int'($urandom_range(0, 17)) : 0;
	endfunction

	function automatic void decode_edge(input ppmfd_pkg::edge_t e);
		logic [15:0] now_us;
		logic [15:0] gap;
		int slot;
		ppmfd_pkg::result_t r;
		if (!e.is_ppm_edge)
			return;
		now_us = e.timestamp_us[15:0];
		gap = now_us - prev_edge_us;
		prev_edge_us = now_us;
		r = '0;
		r.pulse_width_us = gap;
		r.last = 1'b1;
		if (!is_locked) begin
			if (gap >= cfg_sync_min) begin
				is_locked = 1'b1;
				chan_count = '0;
				update_seen = 1'b0;
				r.status = ppmfd_pkg::ST_SYNC;
			end else begin
				r.status = ppmfd_pkg::ST_WAITING;
			end
		end else if (gap >= cfg_sync_min) begin
			chan_count = '0;
			update_seen = 1'b1;
			r.status = ppmfd_pkg::ST_SYNC;
		end else if (gap >= cfg_pulse_min && gap <= cfg_pulse_max) begin
			slot = int'(chan_count);
			if (slot >= NUM_CH)
				slot = 0;
			chan_widths[slot] = gap;
			slot++;
			if (slot >= NUM_CH) begin
				chan_count = '0;
				for (int k = 0; k < NUM_REPORTS; k++) begin
					r.status = ppmfd_pkg::ST_REPORT;
					r.channel_index = 4'(k);
					r.pulse_width_us = chan_widths[k];
					r.frame_seen = update_seen;
					r.last = (k == NUM_REPORTS - 1);
					decoded_results.push_back(r);
				end
				return;
			end
			chan_count = 4'(slot);
			r.status = ppmfd_pkg::ST_STORED;
			r.channel_index = 4'(slot - 1);
		end else begin
			is_locked = 1'b0;
			r.status = ppmfd_pkg::ST_LOST;
		end
		r.frame_seen = update_seen;
		decoded_results.push_back(r);
	endfunction

	task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : edge_driver
		if (!arst_n) begin
			edge_valid <= 1'b0;
		end else begin
			if (edge_valid && edge_ready)
				decode_edge(edge_data);
			if (!edge_valid || edge_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					edge_valid <= 1'b0;
				end else if (edges_to_send.size() != 0) begin
					edge_data <= edges_to_send.pop_front();
					edge_valid <= 1'b1;
					send_wait = draw_wait();
				end else begin
					edge_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		ppmfd_pkg::result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (decoded_results.size() == 0) begin
					$error("result with nothing pending: status %0d", result_data.status);
					error_count++;
				end else begin
					want = decoded_results.pop_front();
					check_field("status", 16'(want.status), 16'(result_data.status));
					check_field("channel_index", 16'(want.channel_index),
						16'(result_data.channel_index));
					check_field("pulse_width_us", want.pulse_width_us,
						result_data.pulse_width_us);
					check_field("frame_seen", 16'(want.frame_seen),
						16'(result_data.frame_seen));
					check_field("last", 16'(want.last), 16'(result_data.last));
				end
				recv_wait = draw_wait();
			end
			if (recv_wait > 0) begin
				recv_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= !hold_off;
			end
		end
	end

	task automatic send_gap(input logic [15:0] gap);
		ppmfd_pkg::edge_t e;
		clock_us = clock_us + 32'(gap);
		e.timestamp_us = clock_us;
		e.is_ppm_edge = 1'b1;
		edges_to_send.push_back(e);
	endtask

	task automatic send_ignored();
		ppmfd_pkg::edge_t e;
		e.timestamp_us = $urandom();
		e.is_ppm_edge = 1'b0;
		edges_to_send.push_back(e);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ppmfd_pkg::CFG_SYNC_MIN: cfg_sync_min = value;
			ppmfd_pkg::CFG_PULSE_MIN: cfg_pulse_min = value;
			ppmfd_pkg::CFG_PULSE_MAX: cfg_pulse_max = value;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (edges_to_send.size() != 0 || edge_valid || decoded_results.size() != 0);
		repeat (NUM_REPORTS + 4) @(posedge clk);
	endtask

	// mostly complete frames, some cut short, some stray gaps
	task automatic queue_traffic(input int edges);
		int sent;
		int kind;
		int n;
		sent = 0;
		while (sent < edges) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				send_gap(16'($urandom_range(cfg_sync_min, 16'hFFFF)));
				for (int k = 0; k < NUM_CH; k++) begin
					if ($urandom_range(0, 15) == 0)
						send_ignored();
					send_gap(16'($urandom_range(cfg_pulse_min, cfg_pulse_max)));
				end
				sent += NUM_CH + 1;
			end else if (kind < 9) begin
				n = $urandom_range(1, NUM_CH - 1);
				send_gap(16'($urandom_range(cfg_sync_min, 16'hFFFF)));
				for (int k = 0; k < n; k++)
					send_gap(16'($urandom_range(cfg_pulse_min, cfg_pulse_max)));
				send_gap(16'($urandom()));
				sent += n + 2;
			end else begin
				send_gap(16'($urandom()));
				send_ignored();
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		logic [15:0] frame_widths [NUM_CH];
		logic [15:0] s_min;
		logic [15:0] p_min;
		logic [15:0] p_max;
		int mode;
		frame_widths = '{16'd950, 16'd2050, 16'd1500, 16'd1234,
			16'd1999, 16'd1001, 16'd2049, 16'd1111};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset thresholds, first edge against zero, window edges, full frame
		send_ignored();
		clock_us = 32'hFFFF_0000;
		send_gap(16'd0);
		send_gap(16'd2199);
		send_gap(16'd2200);
		send_gap(16'd950);
		send_gap(16'd2050);
		send_gap(16'd949);
		send_gap(16'hFFFF);
		send_gap(16'd2051);
		send_gap(16'd3000);
		for (int k = 0; k < NUM_CH; k++) begin
			if (k == 3)
				send_ignored();
			send_gap(frame_widths[k]);
		end
		send_gap(16'd2200);
		send_gap(16'd0);
		wait_idle();

		write_reg(ppmfd_pkg::CFG_SYNC_MIN, 16'h0000);
		write_reg(ppmfd_pkg::CFG_PULSE_MIN, 16'h0000);
		write_reg(ppmfd_pkg::CFG_PULSE_MAX, 16'hFFFF);
		send_gap(16'd0);
		wait_idle();

		for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
			mode = chunk < 2 ? 0 : chunk % 3;
			case (mode)
				0: begin
					s_min = 16'($urandom_range(2000, 3000));
					p_min = 16'($urandom_range(500, 1200));
					p_max = 16'($urandom_range(1500, 2100));
				end
				1: begin
					s_min = 16'($urandom());
					p_min = 16'($urandom());
					p_max = 16'($urandom());
				end
				default: begin
					s_min = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					p_min = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom_range(0, 2000));
					p_max = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1000, 3000));
				end
			endcase
			write_reg(ppmfd_pkg::CFG_SYNC_MIN, s_min);
			write_reg(ppmfd_pkg::CFG_PULSE_MIN, p_min);
			write_reg(ppmfd_pkg::CFG_PULSE_MAX, p_max);
			idle_on = (chunk != 1) && ($urandom_range(0, 3) != 0);
			clock_us[31:16] = 16'($urandom());
			queue_traffic(CHUNK_EDGES);
			if (chunk == 1) begin
				// receiver stalls so the block backs up into its input
				@(posedge clk);
				hold_off <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
			wait_idle();
		end

		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
